[design/pidaw_pkg.sv]
// Package for the PID controller with anti-windup.
// Holds the data widths, reset values and the register map used by all design files.
`default_nettype none

package pidaw_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // Operand width of the shared multiplier: one extra bit for the unsigned time step.
    localparam int MUL_W  = DATA_WIDTH + 1;
    localparam int PROD_W = 2 * MUL_W;

    // Width of the accumulator that holds the exact sum of the three terms.
    localparam int ACC_W  = 2 * DATA_WIDTH - FRAC_BITS + 2;

    // Dividend of the derivative division: |error difference| shifted up by the fraction.
    localparam int DVD_W  = DATA_WIDTH + 1 + FRAC_BITS;
    localparam int CNT_W  = $clog2(DVD_W + 1);

    localparam int NUM_REGS = 6;
    localparam int ADDR_W   = $clog2(NUM_REGS) + 2;

    localparam logic [DATA_WIDTH-1:0] DRIVE_MIN_RESET = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] DRIVE_MAX_RESET = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] TIME_STEP_RESET = DATA_WIDTH'(655);

    typedef enum logic [ADDR_W-3:0] {
        REG_GAIN_P    = 3'd0,
        REG_GAIN_I    = 3'd1,
        REG_GAIN_D    = 3'd2,
        REG_DRIVE_MIN = 3'd3,
        REG_DRIVE_MAX = 3'd4,
        REG_TIME_STEP = 3'd5
    } cfg_reg_t;

endpackage

`default_nettype wire

[design/pidaw_if.sv]
// Valid/ready channel interfaces for the error items and the drive items.
// Depends on pidaw_pkg for the data width.
`default_nettype none

interface pidaw_in_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [pidaw_pkg::DATA_WIDTH-1:0]    error_sample;

    modport source (output valid, output error_sample, input ready);
    modport sink   (input valid, input error_sample, output ready);
endinterface

interface pidaw_out_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [pidaw_pkg::DATA_WIDTH-1:0]    drive;
    logic                                       clamped;

    modport source (output valid, output drive, output clamped, input ready);
    modport sink   (input valid, input drive, input clamped, output ready);
endinterface

`default_nettype wire

[design/pidaw_div.sv]
// Restoring divider that produces one quotient bit per cycle.
// Depends on pidaw_pkg for the dividend and divisor widths.
`default_nettype none

module pidaw_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [pidaw_pkg::DVD_W-1:0]         dividend,
    input  logic [pidaw_pkg::DATA_WIDTH-1:0]    divisor,
    output logic                                busy,
    output logic [pidaw_pkg::DVD_W-1:0]         quotient
);

    localparam int DW    = pidaw_pkg::DATA_WIDTH;
    localparam int DVD_W = pidaw_pkg::DVD_W;
    localparam int CNT_W = pidaw_pkg::CNT_W;

    logic [DW-1:0]      rem_reg;
    logic [DW-1:0]      rem_next;
    logic [DVD_W-1:0]   quo_reg;
    logic [DVD_W-1:0]   quo_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               busy_reg;
    logic               busy_next;
    logic [DW:0]        rem_shift;
    logic [DW:0]        rem_sub;
    logic               fits;

    assign rem_shift = {rem_reg, quo_reg[DVD_W-1]};
    assign rem_sub   = rem_shift - {1'b0, divisor};
    assign fits      = rem_shift >= {1'b0, divisor};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? rem_sub[DW-1:0] : rem_shift[DW-1:0];
            quo_next  = {quo_reg[DVD_W-2:0], fits};
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[design/pid_controller_antiwindup.sv]
// Top level of the PID controller with conditional-integration anti-windup.
// Depends on pidaw_pkg, the channel interfaces in pidaw_if and the divider pidaw_div.
//
// Usage:
// Each input item on in_item carries one signed Q16.16 error sample. For each item the
// block delivers one item on out_item with the clamped drive and a flag that is set
// when the sum lay outside [drive_min, drive_max]; the integral is then held. The user
// must write gains, limits and the time step over the APB port while the block is idle;
// the block itself does not enforce this.
// Sequence and intake:
// The derivative division runs one quotient bit per cycle while the three other products
// go through the single shared multiplier; the derivative product, its accumulation and
// the clamp follow once the division is done. in_item.ready is high only while no item is
// in work, so the block takes no new error sample before the last one is through.
// Stall and reset:
// The result waits in an output register; a new item is accepted meanwhile, and its result
// is held back until the previous one has been taken. Reset clears the integral and the
// previous error, loads the register reset values and empties the output register.
`default_nettype none

module pid_controller_antiwindup (
    input  logic                                clk,
    input  logic                                rst_n,
    pidaw_in_if.sink                            in_item,
    pidaw_out_if.source                         out_item,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pidaw_pkg::ADDR_W-1:0]        paddr,
    input  logic [pidaw_pkg::DATA_WIDTH-1:0]    pwdata,
    output logic [pidaw_pkg::DATA_WIDTH-1:0]    prdata,
    output logic                                pready
);

    localparam int DW     = pidaw_pkg::DATA_WIDTH;
    localparam int FRAC   = pidaw_pkg::FRAC_BITS;
    localparam int MUL_W  = pidaw_pkg::MUL_W;
    localparam int PROD_W = pidaw_pkg::PROD_W;
    localparam int ACC_W  = pidaw_pkg::ACC_W;
    localparam int DVD_W  = pidaw_pkg::DVD_W;
    localparam int ADDR_W = pidaw_pkg::ADDR_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_DMUL,
        S_DACC,
        S_DONE
    } state_t;

    state_t                     state_reg, state_next;
    logic [1:0]                 mstep_reg, mstep_next;
    logic signed [DW-1:0]       gain_p_reg, gain_p_next;
    logic signed [DW-1:0]       gain_i_reg, gain_i_next;
    logic signed [DW-1:0]       gain_d_reg, gain_d_next;
    logic signed [DW-1:0]       drive_min_reg, drive_min_next;
    logic signed [DW-1:0]       drive_max_reg, drive_max_next;
    logic [DW-1:0]              time_step_reg, time_step_next;
    logic signed [DW-1:0]       integ_reg, integ_next;
    logic signed [DW-1:0]       last_err_reg, last_err_next;
    logic signed [DW-1:0]       err_reg, err_next;
    logic                       diff_neg_reg, diff_neg_next;
    logic                       diff_zero_reg, diff_zero_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [DW-1:0]       int_cand_reg, int_cand_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [DW-1:0]       out_drive_reg, out_drive_next;
    logic                       out_clamped_reg, out_clamped_next;

    logic                       cfg_wr;
    pidaw_pkg::cfg_reg_t        cfg_idx;
    logic                       in_acc;
    logic signed [DW:0]         diff;
    logic [DW:0]                diff_abs;
    logic [DVD_W-1:0]           dividend;
    logic                       div_busy;
    logic [DVD_W-1:0]           quotient;
    logic                       quo_over;
    logic signed [DW-1:0]       deriv;
    logic signed [MUL_W-1:0]    mul_a;
    logic signed [MUL_W-1:0]    mul_b;
    logic                       mul_load;
    logic signed [PROD_W-1:0]   mul_prod;
    logic signed [PROD_W-1:0]   prod_shift;
    logic signed [ACC_W-1:0]    term;
    logic signed [ACC_W-1:0]    int_wide;
    logic                       int_ovf;
    logic signed [DW-1:0]       int_sat;
    logic signed [ACC_W-1:0]    min_wide;
    logic signed [ACC_W-1:0]    max_wide;
    logic                       below;
    logic                       above;
    logic                       out_free;

    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = pidaw_pkg::cfg_reg_t'(paddr[ADDR_W-1:2]);
    assign pready  = 1'b1;

    always_comb
    begin
        unique case (cfg_idx)
            pidaw_pkg::REG_GAIN_P:    prdata = gain_p_reg;
            pidaw_pkg::REG_GAIN_I:    prdata = gain_i_reg;
            pidaw_pkg::REG_GAIN_D:    prdata = gain_d_reg;
            pidaw_pkg::REG_DRIVE_MIN: prdata = drive_min_reg;
            pidaw_pkg::REG_DRIVE_MAX: prdata = drive_max_reg;
            pidaw_pkg::REG_TIME_STEP: prdata = time_step_reg;
            default:                  prdata = '0;
        endcase
    end

    assign in_acc   = in_item.valid & (state_reg == S_IDLE);
    assign diff     = {in_item.error_sample[DW-1], in_item.error_sample}
                      - {last_err_reg[DW-1], last_err_reg};
    assign diff_abs = diff[DW] ? (DW+1)'(0) - diff : diff;
    assign dividend = {diff_abs, {FRAC{1'b0}}};

    pidaw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_acc),
        .dividend (dividend),
        .divisor  (time_step_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // The derivative saturates when the quotient does not fit the signed data range.
    // A zero time step gives an all-ones quotient, so an unchanged error is caught first.
    assign quo_over = |quotient[DVD_W-1:DW-1];
    always_comb
    begin
        if (diff_zero_reg)
        begin
            deriv = '0;
        end
        else if (quo_over)
        begin
            deriv = diff_neg_reg ? pidaw_pkg::DRIVE_MIN_RESET : pidaw_pkg::DRIVE_MAX_RESET;
        end
        else
        begin
            deriv = diff_neg_reg ? DW'(0) - quotient[DW-1:0] : quotient[DW-1:0];
        end
    end

    always_comb
    begin
        mul_a    = '0;
        mul_b    = '0;
        mul_load = 1'b0;
        if (state_reg == S_RUN)
        begin
            case (mstep_reg)
                2'd0:
                begin
                    mul_a    = {gain_p_reg[DW-1], gain_p_reg};
                    mul_b    = {err_reg[DW-1], err_reg};
                    mul_load = 1'b1;
                end
                2'd1:
                begin
                    mul_a    = {gain_i_reg[DW-1], gain_i_reg};
                    mul_b    = {integ_reg[DW-1], integ_reg};
                    mul_load = 1'b1;
                end
                2'd2:
                begin
                    mul_a    = {err_reg[DW-1], err_reg};
                    mul_b    = {1'b0, time_step_reg};
                    mul_load = 1'b1;
                end
                default:
                begin
                    mul_load = 1'b0;
                end
            endcase
        end
        else if (state_reg == S_DMUL)
        begin
            mul_a    = {gain_d_reg[DW-1], gain_d_reg};
            mul_b    = {deriv[DW-1], deriv};
            mul_load = 1'b1;
        end
    end

    assign mul_prod   = mul_a * mul_b;
    assign prod_shift = prod_reg >>> FRAC;
    assign term       = prod_shift[ACC_W-1:0];

    assign int_wide = {{(ACC_W-DW){integ_reg[DW-1]}}, integ_reg} + term;
    assign int_ovf  = (int_wide[ACC_W-1:DW-1] != {(ACC_W-DW+1){1'b0}})
                      && (int_wide[ACC_W-1:DW-1] != {(ACC_W-DW+1){1'b1}});
    assign int_sat  = int_ovf ? (int_wide[ACC_W-1] ? pidaw_pkg::DRIVE_MIN_RESET
                                                   : pidaw_pkg::DRIVE_MAX_RESET)
                              : int_wide[DW-1:0];

    assign min_wide = {{(ACC_W-DW){drive_min_reg[DW-1]}}, drive_min_reg};
    assign max_wide = {{(ACC_W-DW){drive_max_reg[DW-1]}}, drive_max_reg};
    assign below    = acc_reg < min_wide;
    assign above    = acc_reg > max_wide;
    assign out_free = !out_valid_reg || out_item.ready;

    always_comb
    begin
        state_next       = state_reg;
        mstep_next       = mstep_reg;
        gain_p_next      = gain_p_reg;
        gain_i_next      = gain_i_reg;
        gain_d_next      = gain_d_reg;
        drive_min_next   = drive_min_reg;
        drive_max_next   = drive_max_reg;
        time_step_next   = time_step_reg;
        integ_next       = integ_reg;
        last_err_next    = last_err_reg;
        err_next         = err_reg;
        diff_neg_next    = diff_neg_reg;
        diff_zero_next   = diff_zero_reg;
        prod_next        = mul_load ? mul_prod : prod_reg;
        acc_next         = acc_reg;
        int_cand_next    = int_cand_reg;
        out_valid_next   = out_valid_reg;
        out_drive_next   = out_drive_reg;
        out_clamped_next = out_clamped_reg;

        if (out_valid_reg && out_item.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_wr)
        begin
            unique case (cfg_idx)
                pidaw_pkg::REG_GAIN_P:    gain_p_next    = pwdata;
                pidaw_pkg::REG_GAIN_I:    gain_i_next    = pwdata;
                pidaw_pkg::REG_GAIN_D:    gain_d_next    = pwdata;
                pidaw_pkg::REG_DRIVE_MIN: drive_min_next = pwdata;
                pidaw_pkg::REG_DRIVE_MAX: drive_max_next = pwdata;
                pidaw_pkg::REG_TIME_STEP: time_step_next = pwdata;
                default:                  gain_p_next    = gain_p_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    err_next       = in_item.error_sample;
                    last_err_next  = in_item.error_sample;
                    diff_neg_next  = diff[DW];
                    diff_zero_next = (diff == '0);
                    mstep_next     = 2'd0;
                    state_next     = S_RUN;
                end
            end
            S_RUN:
            begin
                case (mstep_reg)
                    2'd0:
                    begin
                        mstep_next = 2'd1;
                    end
                    2'd1:
                    begin
                        acc_next   = term;
                        mstep_next = 2'd2;
                    end
                    2'd2:
                    begin
                        acc_next   = acc_reg + term;
                        mstep_next = 2'd3;
                    end
                    default:
                    begin
                        int_cand_next = int_sat;
                        if (!div_busy)
                        begin
                            state_next = S_DMUL;
                        end
                    end
                endcase
            end
            S_DMUL:
            begin
                state_next = S_DACC;
            end
            S_DACC:
            begin
                acc_next   = acc_reg + term;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_clamped_next = below | above;
                    if (below)
                    begin
                        out_drive_next = drive_min_reg;
                    end
                    else if (above)
                    begin
                        out_drive_next = drive_max_reg;
                    end
                    else
                    begin
                        out_drive_next = acc_reg[DW-1:0];
                        integ_next     = int_cand_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            mstep_reg       <= 2'd0;
            gain_p_reg      <= '0;
            gain_i_reg      <= '0;
            gain_d_reg      <= '0;
            drive_min_reg   <= pidaw_pkg::DRIVE_MIN_RESET;
            drive_max_reg   <= pidaw_pkg::DRIVE_MAX_RESET;
            time_step_reg   <= pidaw_pkg::TIME_STEP_RESET;
            integ_reg       <= '0;
            last_err_reg    <= '0;
            err_reg         <= '0;
            diff_neg_reg    <= 1'b0;
            diff_zero_reg   <= 1'b0;
            prod_reg        <= '0;
            acc_reg         <= '0;
            int_cand_reg    <= '0;
            out_valid_reg   <= 1'b0;
            out_drive_reg   <= '0;
            out_clamped_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            mstep_reg       <= mstep_next;
            gain_p_reg      <= gain_p_next;
            gain_i_reg      <= gain_i_next;
            gain_d_reg      <= gain_d_next;
            drive_min_reg   <= drive_min_next;
            drive_max_reg   <= drive_max_next;
            time_step_reg   <= time_step_next;
            integ_reg       <= integ_next;
            last_err_reg    <= last_err_next;
            err_reg         <= err_next;
            diff_neg_reg    <= diff_neg_next;
            diff_zero_reg   <= diff_zero_next;
            prod_reg        <= prod_next;
            acc_reg         <= acc_next;
            int_cand_reg    <= int_cand_next;
            out_valid_reg   <= out_valid_next;
            out_drive_reg   <= out_drive_next;
            out_clamped_reg <= out_clamped_next;
        end
    end

    assign in_item.ready    = (state_reg == S_IDLE);
    assign out_item.valid   = out_valid_reg;
    assign out_item.drive   = out_drive_reg;
    assign out_item.clamped = out_clamped_reg;

endmodule

`default_nettype wire
